FILE: hdl/imu_frame_sync_crc_check_macros.svh
// Assertion macros for the IMU frame synchronizer with CRC check.
// Included by the top level; the macros expect aclk and aresetn in scope.
`ifndef IMU_FRAME_SYNC_CRC_CHECK_MACROS_SVH
`define IMU_FRAME_SYNC_CRC_CHECK_MACROS_SVH

// Same-cycle property, disabled during reset.
`define IMU_FSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property of the form "antecedent, then consequent in the next cycle".
`define IMU_FSC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: hdl/imu_fsc_pkg.sv
// Shared types, constants and the byte-wide CRC-32 update for the IMU frame synchronizer.
// No dependencies.
package imu_fsc_pkg;

    localparam int unsigned IDX_W              = 7;
    localparam int unsigned FRAME_BYTES_DEF    = 42;
    localparam int unsigned PAD_BYTES_DEF      = 2;
    localparam logic [7:0]  HEADER_RESET       = 8'd147;
    localparam logic [31:0] CRC_POLY           = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT           = 32'hFFFF_FFFF;
    localparam logic [7:0]  PAD_VALUE          = 8'h00;
    localparam int unsigned OUT_FIELDS_W       = 65;
    localparam int unsigned OUT_TDATA_W        = 72;

    typedef struct packed {
        logic        last;
        logic        crc_ok;
        logic [31:0] computed_crc;
        logic [31:0] received_crc;
    } frame_res_t;

    // One byte through the CRC-32, MSB first, no reflection.
    function automatic logic [31:0] crc_feed(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {b, 24'h0};
        for (int k = 0; k < 8; k++) begin
            if (c[31]) begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: hdl/imu_frame_sync_crc_check.sv
// Top level of the IMU frame synchronizer with CRC-32 check.
// Depends on imu_fsc_pkg, imu_fsc_frame and imu_frame_sync_crc_check_macros.svh.
//
// Takes one received byte per transfer and hunts for the header byte; from
// there it counts off a FRAME_BYTES frame, runs the CRC-32 (poly 04C11DB7,
// init all ones, no reflection, no final XOR) over all bytes before the last
// four plus PAD_BYTES zero bytes, and on the last byte emits one result with
// the pass flag, the computed CRC and the received CRC (first byte MSB).
// A byte is taken every cycle: the input register feeds a byte-wide CRC
// update and counter, and a result is registered in the output register
// when its last byte leaves the input register. Input stalls only when a
// frame's last byte meets a result that the sink has not yet taken. header_byte
// is written over the cfg channel only while no byte is held; it resets to 147.
`include "imu_frame_sync_crc_check_macros.svh"

module imu_frame_sync_crc_check #(
    parameter int unsigned FRAME_BYTES = imu_fsc_pkg::FRAME_BYTES_DEF,
    parameter int unsigned PAD_BYTES   = imu_fsc_pkg::PAD_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,     // header_byte
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [imu_fsc_pkg::OUT_TDATA_W-1:0] m_tdata
    // m_tdata: [0] crc_ok, [32:1] computed_crc, [64:33] received_crc, [71:65] zero
);
    import imu_fsc_pkg::*;

    logic [7:0]  header_reg;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [OUT_FIELDS_W-1:0] out_reg;

    logic        out_free, advance, s_accept, emit, in_stall, out_crc_eq;
    frame_res_t  res;

    imu_fsc_frame #(
        .FRAME_BYTES (FRAME_BYTES),
        .PAD_BYTES   (PAD_BYTES)
    ) u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .header_byte (header_reg),
        .rx_byte     (in_byte_reg),
        .step        (advance),
        .res         (res)
    );

    always_comb begin
        out_free      = !m_tvalid_reg || m_tready;
        advance       = in_valid_reg && (!res.last || out_free);
        emit          = advance && res.last;
        in_stall      = in_valid_reg && !advance;
        s_tready      = !in_valid_reg || advance;
        s_accept      = s_tvalid && s_tready;
        in_valid_next = s_accept || (in_valid_reg && !advance);
        m_tvalid_next = emit || (m_tvalid_reg && !m_tready);
        out_crc_eq    = (out_reg[32:1] == out_reg[64:33]);
    end

    // A header write waits until no byte is held, so it never lands between
    // a byte's transfer and its processing.
    assign cfg_ready = !in_valid_reg;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            header_reg   <= HEADER_RESET;
            in_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                header_reg <= cfg_data;
            end
            in_valid_reg <= in_valid_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_tdata;
        end
        if (emit) begin
            out_reg <= {res.received_crc, res.computed_crc, res.crc_ok};
        end
    end

    `IMU_FSC_ASSERT(a_emit_into_free_slot, emit |-> out_free, "result overwrote a pending one")
    `IMU_FSC_ASSERT(a_rise_after_emit, $rose(m_tvalid_reg) |-> $past(emit), "stray valid")
    `IMU_FSC_ASSERT(a_flag_matches, m_tvalid_reg |-> (out_reg[0] == out_crc_eq), "bad pass flag")
    `IMU_FSC_ASSERT_NEXT(a_held_byte, in_stall, in_valid_reg && $stable(in_byte_reg), "byte lost")

endmodule

FILE: hdl/imu_fsc_frame.sv
// Frame tracker: header hunt, byte counter, running CRC and received CRC field.
// Depends on imu_fsc_pkg.
module imu_fsc_frame #(
    parameter int unsigned FRAME_BYTES = imu_fsc_pkg::FRAME_BYTES_DEF,
    parameter int unsigned PAD_BYTES   = imu_fsc_pkg::PAD_BYTES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [7:0]              header_byte,
    input  logic [7:0]              rx_byte,
    input  logic                    step,
    output imu_fsc_pkg::frame_res_t res
);
    import imu_fsc_pkg::*;

    localparam logic [IDX_W-1:0] FIELD_IDX = IDX_W'(FRAME_BYTES - 4);
    localparam logic [IDX_W-1:0] PAD_END   = IDX_W'(FRAME_BYTES - 4 + PAD_BYTES);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_BYTES - 1);

    logic             in_frame_reg, in_frame_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [31:0]      crc_reg, crc_next;
    logic [31:0]      field_reg, field_next;

    logic             start, active, last;
    logic [IDX_W-1:0] cur_idx;
    logic [31:0]      cur_crc, cur_field, crc_upd, field_upd;

    always_comb begin
        start     = !in_frame_reg && (rx_byte == header_byte);
        active    = in_frame_reg || start;
        cur_idx   = in_frame_reg ? idx_reg : '0;
        cur_crc   = in_frame_reg ? crc_reg : CRC_INIT;
        cur_field = in_frame_reg ? field_reg : '0;

        // The zero padding is fed while the CRC field bytes arrive, so the
        // CRC is complete by the last byte.
        if (cur_idx < FIELD_IDX) begin
            crc_upd = crc_feed(cur_crc, rx_byte);
        end else if (cur_idx < PAD_END) begin
            crc_upd = crc_feed(cur_crc, PAD_VALUE);
        end else begin
            crc_upd = cur_crc;
        end
        field_upd = (cur_idx >= FIELD_IDX) ? {cur_field[23:0], rx_byte} : cur_field;
        last      = active && (cur_idx == LAST_IDX);

        res.last         = last;
        res.crc_ok       = (crc_upd == field_upd);
        res.computed_crc = crc_upd;
        res.received_crc = field_upd;

        in_frame_next = in_frame_reg;
        idx_next      = idx_reg;
        crc_next      = crc_reg;
        field_next    = field_reg;
        if (last) begin
            in_frame_next = 1'b0;
            idx_next      = '0;
            crc_next      = CRC_INIT;
            field_next    = '0;
        end else if (active) begin
            in_frame_next = 1'b1;
            idx_next      = cur_idx + IDX_W'(1);
            crc_next      = crc_upd;
            field_next    = field_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            idx_reg      <= '0;
            crc_reg      <= CRC_INIT;
            field_reg    <= '0;
        end else if (step) begin
            in_frame_reg <= in_frame_next;
            idx_reg      <= idx_next;
            crc_reg      <= crc_next;
            field_reg    <= field_next;
        end
    end

endmodule

FILE: bench/imu_fsc_checker.sv
// Scoreboard for the IMU frame synchronizer: a bit-serial CRC-32 helper package and a checker
// that tracks frame sync, predicts every verdict and compares it with the result channel.
// Depends on imu_fsc_pkg.
`timescale 1ns / 1ps

package frame_crc_util_pkg;

    // Bit-serial form of the MSB-first CRC-32: feedback is the top bit XOR the next data bit.
    function automatic logic [31:0] crc32_next_byte(input logic [31:0] acc, input logic [7:0] data);
        logic [31:0] r;
        r = acc;
        for (int i = 7; i >= 0; i--) begin
            r = {r[30:0], 1'b0} ^ ((r[31] ^ data[i]) ? imu_fsc_pkg::CRC_POLY : 32'h0);
        end
        return r;
    endfunction

endpackage

module imu_fsc_checker #(
    parameter int unsigned FRAME_LEN = 42,
    parameter int unsigned PAD_LEN   = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [imu_fsc_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int          mismatches,
    output int          outstanding,
    output int          verdicts_checked
);
    import imu_fsc_pkg::*;
    import frame_crc_util_pkg::*;

    typedef struct packed {
        logic        crc_ok;
        logic [31:0] computed_crc;
        logic [31:0] received_crc;
    } crc_verdict_t;

    crc_verdict_t           verdict_q[$];
    logic [7:0]             header_sel;
    logic                   framing;
    logic [IDX_W-1:0]       byte_pos;
    logic [31:0]            body_crc;
    logic [31:0]            tail_field;

    task automatic rearm_hunt();
        framing    = 1'b0;
        byte_pos   = '0;
        body_crc   = CRC_INIT;
        tail_field = '0;
    endtask

    task automatic field_check(input string label, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        crc_verdict_t want;
        logic [31:0]  padded;
        if (!aresetn) begin
            header_sel = HEADER_RESET;
            rearm_hunt();
            verdict_q.delete();
            mismatches       = 0;
            verdicts_checked = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                header_sel = cfg_data;
            end
            // While hunting, anything but the header byte is dropped without a trace.
            if (s_tvalid && s_tready && (framing || s_tdata == header_sel)) begin
                framing = 1'b1;
                if (byte_pos < FRAME_LEN - 4) begin
                    body_crc = crc32_next_byte(body_crc, s_tdata);
                end else begin
                    tail_field = {tail_field[23:0], s_tdata};
                end
                if (byte_pos >= FRAME_LEN - 1) begin
                    padded = body_crc;
                    repeat (PAD_LEN) padded = crc32_next_byte(padded, PAD_VALUE);
                    want.crc_ok       = (padded == tail_field);
                    want.computed_crc = padded;
                    want.received_crc = tail_field;
                    verdict_q.push_back(want);
                    rearm_hunt();
                end else begin
                    byte_pos = byte_pos + 1'b1;
                end
            end
            if (m_tvalid && m_tready) begin
                if (verdict_q.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual ok=%0b crc=%h rx=%h",
                             $time, m_tdata[0], m_tdata[32:1], m_tdata[64:33]);
                    mismatches++;
                end else begin
                    want = verdict_q.pop_front();
                    field_check("crc_ok", 32'(want.crc_ok), 32'(m_tdata[0]));
                    field_check("computed_crc", want.computed_crc, m_tdata[32:1]);
                    field_check("received_crc", want.received_crc, m_tdata[64:33]);
                    field_check("tdata padding", 32'h0, 32'(m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W]));
                    verdicts_checked++;
                end
            end
        end
        outstanding = verdict_q.size();
    end

endmodule

FILE: bench/tb_imu_frame_sync_crc_check.sv
// Top of the IMU frame synchronizer bench: clock, reset, byte stimulus, header writes and verdict.
// Depends on imu_fsc_pkg, frame_crc_util_pkg, imu_fsc_checker and imu_frame_sync_crc_check.
`timescale 1ns / 1ps

module tb_imu_frame_sync_crc_check;
    import imu_fsc_pkg::*;
    import frame_crc_util_pkg::*;

    localparam int unsigned FRAME_LEN      = FRAME_BYTES_DEF;
    localparam int unsigned PAD_LEN        = PAD_BYTES_DEF;
    localparam int          ITEM_TARGET    = 1600;
    localparam int          STALL_PCT      = 14;
    localparam int          WATCHDOG_LIMIT = 5000;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [7:0]              cfg_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [7:0]              s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_TDATA_W-1:0]  m_tdata;

    int         mismatches;
    int         outstanding;
    int         verdicts_checked;
    int         bytes_sent    = 0;
    int         full_frames   = 0;
    int         header_writes = 0;
    int         idle_cycles   = 0;
    logic       gaps_on;
    logic [7:0] hdr_now;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    imu_frame_sync_crc_check #(
        .FRAME_BYTES (FRAME_LEN),
        .PAD_BYTES   (PAD_LEN)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    imu_fsc_checker #(
        .FRAME_LEN (FRAME_LEN),
        .PAD_LEN   (PAD_LEN)
    ) checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .verdicts_checked (verdicts_checked)
    );

    always @(posedge aclk) begin
        m_tready <= gaps_on ? ($urandom_range(99) >= STALL_PCT) : 1'b1;
    end

    // Ends the run if no transfer of any kind happens for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results still due",
                     idle_cycles, outstanding);
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Ready is sampled at the falling edge, where it already holds its value for the next
    // rising edge, so the transfer is decided without racing the block's own updates.
    task automatic send_byte(input logic [7:0] b);
        bit taken;
        if (gaps_on && $urandom_range(99) < STALL_PCT / 2) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        bytes_sent++;
    endtask

    task automatic make_frame(input logic [7:0] hdr, input bit corrupt, output logic [7:0] fr[$]);
        logic [31:0] crc;
        logic [7:0]  b;
        int          pick;
        fr = {};
        fr.push_back(hdr);
        crc = crc32_next_byte(CRC_INIT, hdr);
        for (int i = 1; i < FRAME_LEN - 4; i++) begin
            case ($urandom_range(15))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                2:       b = hdr;
                default: b = 8'($urandom);
            endcase
            fr.push_back(b);
            crc = crc32_next_byte(crc, b);
        end
        repeat (PAD_LEN) crc = crc32_next_byte(crc, PAD_VALUE);
        for (int i = 3; i >= 0; i--) fr.push_back(crc[8*i +: 8]);
        // A single flipped bit anywhere past the header always breaks the check.
        if (corrupt) begin
            pick = $urandom_range(FRAME_LEN - 1, 1);
            fr[pick] = fr[pick] ^ 8'(1 << $urandom_range(7));
        end
    endtask

    task automatic send_frame(input logic [7:0] hdr, input bit corrupt);
        logic [7:0] fr[$];
        make_frame(hdr, corrupt, fr);
        foreach (fr[i]) send_byte(fr[i]);
        full_frames++;
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_header(input logic [7:0] v);
        bit taken;
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do begin
            @(negedge aclk);
            taken = cfg_ready;
            @(posedge aclk);
        end while (!taken);
        cfg_valid <= 1'b0;
        hdr_now = v;
        header_writes++;
    endtask

    initial begin
        logic [7:0] fr[$];
        int         pick;
        int         cut;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 8'h00;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'h00;
        gaps_on   <= 1'b1;
        hdr_now = HEADER_RESET;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Stray bytes while hunting, including neighbors of the header value.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(HEADER_RESET - 8'd1);
        send_byte(HEADER_RESET + 8'd1);
        send_frame(hdr_now, 1'b0);
        send_frame(hdr_now, 1'b1);

        // Header changed in the middle of a frame: the frame runs to its end unchanged.
        make_frame(hdr_now, 1'b0, fr);
        for (int i = 0; i < 12; i++) send_byte(fr[i]);
        write_header(8'h00);
        for (int i = 12; i < FRAME_LEN; i++) send_byte(fr[i]);
        full_frames++;
        send_frame(8'h00, 1'b0);
        write_header(8'hFF);
        send_frame(8'hFF, 1'b0);
        send_frame(8'hFF, 1'b1);

        // Mostly intact frames, with stray bytes, cut-off frames and bad CRCs mixed in.
        // The second phase runs with both sides streaming without pauses.
        for (int ph = 0; ph < 4; ph++) begin
            write_header(ph == 1 ? HEADER_RESET : 8'($urandom));
            gaps_on <= (ph != 1);
            while (bytes_sent < (ph + 1) * ITEM_TARGET / 4) begin
                pick = $urandom_range(99);
                if (pick < 12) begin
                    repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
                end else if (pick < 22) begin
                    make_frame(hdr_now, 1'b0, fr);
                    cut = $urandom_range(FRAME_LEN - 1, 1);
                    for (int i = 0; i < cut; i++) send_byte(fr[i]);
                end else begin
                    send_frame(hdr_now, pick < 37);
                end
            end
        end

        settle();
        $display("Sent %0d bytes holding %0d whole frames under %0d header settings;",
                 bytes_sent, full_frames, header_writes);
        $display("%0d frame verdicts were compared, %0d mismatches.", verdicts_checked, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+hdl
hdl/imu_fsc_pkg.sv
hdl/imu_fsc_frame.sv
hdl/imu_frame_sync_crc_check.sv
bench/imu_fsc_checker.sv
bench/tb_imu_frame_sync_crc_check.sv
